// File: hdl/glbt_pkg.sv
package glbt_pkg;

  // Channel levels as kept in the table and reported on the result.
  typedef enum logic [1:0] {
    LVL_GREEN  = 2'd0,
    LVL_YELLOW = 2'd1,
    LVL_RED    = 2'd2
  } level_e;

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_START  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_STABLE_NEEDED = 1'b0;
  localparam logic REG_FALL_PCT      = 1'b1;

  localparam logic [7:0] STABLE_NEEDED_RST = 8'd3;
  localparam logic [6:0] FALL_PCT_RST      = 7'd20;
  localparam logic [7:0] STABLE_MAX        = 8'hFF;

  // Scale of the percentage-drop test.
  localparam logic [6:0] DROP_SCALE = 7'd100;
  localparam int unsigned PROD_W = 39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_MUL,
    ST_WB
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic rd;
    logic ev;
    logic mul;
    logic wb;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } status_t;

  // One table entry.
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] last;
    logic [31:0] peak;
    logic [7:0]  stable;
    level_e      lvl;
  } entry_t;

endpackage

// File: hdl/glbt_cfg.sv
module glbt_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  stable_needed_o,
  output logic [6:0]  fall_pct_o
);
  import glbt_pkg::*;

  logic [7:0] need_q, need_d;
  logic [6:0] pct_q, pct_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    need_d = need_q;
    pct_d  = pct_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_STABLE_NEEDED: need_d = pwdata[7:0];
        REG_FALL_PCT:      pct_d  = pwdata[6:0];
        default:           need_d = need_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= STABLE_NEEDED_RST;
      pct_q  <= FALL_PCT_RST;
    end else begin
      need_q <= need_d;
      pct_q  <= pct_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STABLE_NEEDED: prdata = {24'd0, need_q};
      REG_FALL_PCT:      prdata = {25'd0, pct_q};
      default:           prdata = 32'd0;
    endcase
  end

  assign stable_needed_o = need_q;
  assign fall_pct_o      = pct_q;

endmodule

// File: hdl/glbt_ctrl.sv
module glbt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  glbt_pkg::status_t status_i,
  output glbt_pkg::cmd_t    cmd_o
);
  import glbt_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;
  logic        can_wb;

  assign can_wb = (state_q == ST_WB) && !status_i.out_busy;
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RD;
      ST_RD:   state_d = ST_EV;
      ST_EV:   state_d = ST_MUL;
      ST_MUL:  state_d = ST_WB;
      ST_WB: begin
        if (can_wb) state_d = accept ? ST_RD : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    // A new request may enter as the previous one writes back.
    in_stall_o    = !((state_q == ST_IDLE) || can_wb);
    cmd_o.capture = accept;
    cmd_o.rd      = (state_q == ST_RD);
    cmd_o.ev      = (state_q == ST_EV);
    cmd_o.mul     = (state_q == ST_MUL);
    cmd_o.wb      = can_wb;
  end

endmodule

// File: hdl/glbt_dp.sv
module glbt_dp #(
  parameter int unsigned NUM_CHANNELS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  glbt_pkg::cmd_t    cmd_i,
  output glbt_pkg::status_t status_o,
  input  logic [7:0]        stable_needed_i,
  input  logic [6:0]        fall_pct_i,
  input  logic              kind_i,
  input  logic [5:0]        channel_i,
  input  logic [31:0]       level_kb_i,
  input  logic [31:0]       threshold_kb_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [5:0]        out_channel_o,
  output logic [1:0]        bucket_o,
  output logic [1:0]        previous_bucket_o,
  output logic              trace_on_o,
  output logic              trace_off_o
);
  import glbt_pkg::*;

  localparam int unsigned IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Request registers.
  logic        kind_q;
  logic [5:0]  ch_q;
  logic [31:0] level_q;
  logic [31:0] thr_q;

  // Table and its valid bits.
  entry_t      mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_q;
  entry_t      rd_q;
  logic        rd_vld_q;

  // Evaluation registers.
  logic        ge_growth_q, ge_step_q, le_step_q, thr_zero_q;
  logic [31:0] peak_new_q, drop_q;
  logic [PROD_W-1:0] prod_drop_q, prod_lim_q;
  logic        peak_nz_q;

  logic [31:0] ch_ext;
  logic [IW-1:0] idx;
  logic        in_range;
  level_e      prev_lvl;
  logic [7:0]  prev_stable;
  logic [32:0] growth_lim, step_lim;
  logic [31:0] peak_new;

  entry_t      wr_entry;
  level_e      cur;
  logic [7:0]  sc_inc;
  logic        drop_ok;

  logic        out_valid_q;
  logic [5:0]  out_ch_q;
  logic [1:0]  bucket_q, prev_q;
  logic        on_q, off_q;

  assign ch_ext   = {26'd0, ch_q};
  assign idx      = ch_ext[IW-1:0];
  assign in_range = ch_ext < 32'(NUM_CHANNELS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      ch_q    <= channel_i;
      level_q <= level_kb_i;
      thr_q   <= threshold_kb_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= mem_q[idx];
    end
    if (cmd_i.wb && in_range) begin
      mem_q[idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.rd) rd_vld_q <= vld_q[idx];
      if (cmd_i.wb && in_range) vld_q[idx] <= 1'b1;
    end
  end

  // An entry never written reads as green with no stable samples.
  assign prev_lvl    = rd_vld_q ? rd_q.lvl : LVL_GREEN;
  assign prev_stable = rd_vld_q ? rd_q.stable : 8'd0;

  // Signed growth >= threshold is the same as level >= stored + threshold.
  assign growth_lim = {1'b0, rd_q.base} + {1'b0, thr_q};
  assign step_lim   = {1'b0, rd_q.last} + {1'b0, thr_q};
  assign peak_new   = (level_q > rd_q.peak) ? level_q : rd_q.peak;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev) begin
      ge_growth_q <= {1'b0, level_q} >= growth_lim;
      ge_step_q   <= {1'b0, level_q} >= step_lim;
      le_step_q   <= level_q <= rd_q.last;
      thr_zero_q  <= thr_q == 32'd0;
      peak_new_q  <= peak_new;
      drop_q      <= peak_new - level_q;
    end
    if (cmd_i.mul) begin
      prod_drop_q <= PROD_W'(drop_q) * PROD_W'(DROP_SCALE);
      prod_lim_q  <= PROD_W'(fall_pct_i) * PROD_W'(peak_new_q);
      peak_nz_q   <= peak_new_q != 32'd0;
    end
  end

  assign drop_ok = peak_nz_q && (prod_drop_q >= prod_lim_q);
  assign sc_inc  = (prev_stable == STABLE_MAX) ? prev_stable : prev_stable + 8'd1;

  always_comb begin
    wr_entry.base   = rd_q.base;
    wr_entry.last   = level_q;
    wr_entry.peak   = rd_q.peak;
    wr_entry.stable = prev_stable;
    cur             = prev_lvl;
    if (kind_q == KIND_START) begin
      wr_entry.base   = level_q;
      wr_entry.peak   = level_q;
      wr_entry.stable = 8'd0;
      cur             = LVL_GREEN;
    end else if (thr_zero_q) begin
      wr_entry.stable = 8'd0;
      cur             = LVL_GREEN;
    end else begin
      unique case (prev_lvl)
        LVL_GREEN: begin
          if (ge_growth_q) begin
            cur             = LVL_YELLOW;
            wr_entry.stable = 8'd0;
          end
        end
        LVL_YELLOW: begin
          priority if (ge_step_q) begin
            cur             = LVL_RED;
            wr_entry.peak   = level_q;
            wr_entry.stable = 8'd0;
          end else if (!ge_growth_q) begin
            cur             = LVL_GREEN;
            wr_entry.base   = level_q;
            wr_entry.stable = 8'd0;
          end else if (le_step_q) begin
            if (sc_inc >= stable_needed_i) begin
              cur             = LVL_GREEN;
              wr_entry.base   = level_q;
              wr_entry.stable = 8'd0;
            end else begin
              wr_entry.stable = sc_inc;
            end
          end else begin
            wr_entry.stable = 8'd0;
          end
        end
        default: begin
          // Red: follow the peak, recover, or fall back after a large drop.
          wr_entry.peak = peak_new_q;
          priority if (!ge_growth_q) begin
            cur             = LVL_GREEN;
            wr_entry.base   = level_q;
            wr_entry.stable = 8'd0;
          end else if (le_step_q && drop_ok) begin
            cur             = LVL_YELLOW;
            wr_entry.stable = 8'd0;
          end else begin
            cur = prev_lvl;
          end
        end
      endcase
    end
    wr_entry.lvl = cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wb) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // A start request never raises either trace flag.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      out_ch_q <= ch_q;
      if (!in_range) begin
        bucket_q <= LVL_GREEN;
        prev_q   <= LVL_GREEN;
        on_q     <= 1'b0;
        off_q    <= 1'b0;
      end else begin
        bucket_q <= cur;
        prev_q   <= prev_lvl;
        on_q     <= (kind_q == KIND_SAMPLE) && (cur != prev_lvl) && (prev_lvl == LVL_GREEN);
        off_q    <= (kind_q == KIND_SAMPLE) && (cur != prev_lvl) && (cur == LVL_GREEN);
      end
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_channel_o     = out_ch_q;
  assign bucket_o          = bucket_q;
  assign previous_bucket_o = prev_q;
  assign trace_on_o        = on_q;
  assign trace_off_o       = off_q;

endmodule

// File: hdl/growth_level_bucket_tracker.sv
// Three-level growth monitor over a table of NUM_CHANNELS channels. Each
// request is a start (new baseline, channel goes green) or a sample, which
// moves the channel between green, yellow and red by its own threshold, and
// each request returns one result with the new and previous level plus
// trace-on and trace-off flags. A request passes through reading the
// channel's table entry, comparing the level against baseline and last
// sample, the two multiplications of the percentage-drop test, and
// deciding and writing the entry back; the next request is taken in that
// write-back step. A result waiting in the output register does not block
// the next request until it too is ready to write back. Channels at or
// above NUM_CHANNELS change nothing and return all-zero levels and flags.
// Sampling a channel never started returns undefined levels. Configuration
// is to be written over the APB port only while no request is in flight;
// the block does not enforce this. Register 0 at address 0 is the
// stable-sample count, register 1 at address 4 is the drop percentage.
module growth_level_bucket_tracker #(
  parameter int unsigned NUM_CHANNELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [5:0]  channel_i,
  input  logic [31:0] level_kb_i,
  input  logic [31:0] threshold_kb_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  out_channel_o,
  output logic [1:0]  bucket_o,
  output logic [1:0]  previous_bucket_o,
  output logic        trace_on_o,
  output logic        trace_off_o
);
  import glbt_pkg::*;

  cmd_t       cmd;
  status_t    status;
  logic [7:0] stable_needed;
  logic [6:0] fall_pct;

  // Register file for the two configuration values.
  glbt_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .stable_needed_o (stable_needed),
    .fall_pct_o      (fall_pct)
  );

  // Sequencer: read, evaluate, multiply, write back.
  glbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Channel table, bucket rules and the output register.
  glbt_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .stable_needed_i   (stable_needed),
    .fall_pct_i        (fall_pct),
    .kind_i            (kind_i),
    .channel_i         (channel_i),
    .level_kb_i        (level_kb_i),
    .threshold_kb_i    (threshold_kb_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_channel_o     (out_channel_o),
    .bucket_o          (bucket_o),
    .previous_bucket_o (previous_bucket_o),
    .trace_on_o        (trace_on_o),
    .trace_off_o       (trace_off_o)
  );

endmodule

// File: bench/tb_growth_level_bucket_tracker.sv
module tb_growth_level_bucket_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import glbt_pkg::*;

  localparam int NUM_CH = 64;

  // One request as offered to the block.
  typedef struct packed {
    logic        kind;
    logic [5:0]  ch;
    logic [31:0] level;
    logic [31:0] thr;
  } request_t;

  // One result as it should come out of the block.
  typedef struct packed {
    logic [5:0] ch;
    level_e     bucket;
    level_e     prev;
    logic       on;
    logic       off;
  } bucket_res_t;

  // Clock, reset and all block inputs start at known values.
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic        in_valid_i     = 1'b0;
  logic        kind_i         = KIND_SAMPLE;
  logic [5:0]  channel_i      = '0;
  logic [31:0] level_kb_i     = '0;
  logic [31:0] threshold_kb_i = '0;
  logic        out_stall_i    = 1'b0;

  logic [31:0] prdata;
  logic        pready;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [5:0]  out_channel_o;
  logic [1:0]  bucket_o;
  logic [1:0]  previous_bucket_o;
  logic        trace_on_o;
  logic        trace_off_o;

  growth_level_bucket_tracker #(
    .NUM_CHANNELS(NUM_CH)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .channel_i        (channel_i),
    .level_kb_i       (level_kb_i),
    .threshold_kb_i   (threshold_kb_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_channel_o    (out_channel_o),
    .bucket_o         (bucket_o),
    .previous_bucket_o(previous_bucket_o),
    .trace_on_o       (trace_on_o),
    .trace_off_o      (trace_off_o)
  );

  // Requests waiting to be offered, and results still owed by the block.
  request_t    request_q[$];
  bucket_res_t bucket_exp_q[$];

  // Shadow of the block's channel table and registers, kept by the predictor.
  level_e      chan_lvl  [NUM_CH];
  logic [31:0] chan_base [NUM_CH];
  logic [31:0] chan_last [NUM_CH];
  logic [31:0] chan_peak [NUM_CH];
  logic [7:0]  chan_stab [NUM_CH];
  logic [7:0]  cfg_stable = STABLE_NEEDED_RST;
  logic [6:0]  cfg_drop   = FALL_PCT_RST;

  // What the stimulus generator knows of each channel. A sample is only
  // ever sent to a channel that has had a start, so no unwritten level is read.
  bit          gen_started [NUM_CH];
  logic [31:0] gen_last    [NUM_CH];
  logic [31:0] gen_thr     [NUM_CH];

  int mismatches = 0;
  int idle_pct   = 10;  // chance per cycle that either side idles
  int hold_seq   = 0;   // bumped by the stimulus to start a long receiver hold
  int hold_seen  = 0;
  int hold_left  = 0;
  logic req_taken = 1'b0;

  initial begin
    foreach (chan_lvl[i]) begin
      chan_lvl[i]  = LVL_GREEN;
      chan_stab[i] = '0;
      chan_base[i] = '0;
      chan_last[i] = '0;
      chan_peak[i] = '0;
    end
  end

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The percentage-drop test from the peak. Products are kept in 64 bits so
  // that peak * percent and drop * 100 never wrap.
  function automatic bit drop_reached(input logic [31:0] pk, input logic [31:0] lvl);
    longint unsigned drop;
    if (pk == 0 || lvl >= pk) return (pk != 0) && (cfg_drop == 0);
    drop = longint'(pk) - longint'(lvl);
    return drop * longint'(DROP_SCALE) >= longint'(cfg_drop) * longint'(pk);
  endfunction

  // Applies one request to the shadow table and returns the result the
  // block should produce for it.
  function automatic bucket_res_t bucket_step(input request_t rq);
    bucket_res_t res;
    level_e      prv;
    level_e      nxt;
    longint      growth;
    longint      stp;
    longint      t;
    logic [31:0] lvl;
    res = '{ch: rq.ch, bucket: LVL_GREEN, prev: LVL_GREEN, on: 1'b0, off: 1'b0};
    if (int'(rq.ch) >= NUM_CH) return res;
    lvl = rq.level;
    prv = chan_lvl[rq.ch];
    if (rq.kind == KIND_START) begin
      chan_base[rq.ch] = lvl;
      chan_last[rq.ch] = lvl;
      chan_peak[rq.ch] = lvl;
      chan_lvl[rq.ch]  = LVL_GREEN;
      chan_stab[rq.ch] = '0;
      res.prev = prv;
      return res;
    end
    // Growth and step are exact signed differences of unsigned levels.
    growth = longint'(lvl) - longint'(chan_base[rq.ch]);
    stp    = longint'(lvl) - longint'(chan_last[rq.ch]);
    t      = longint'(rq.thr);
    nxt    = prv;
    if (rq.thr == 0) begin
      nxt = LVL_GREEN;
      chan_stab[rq.ch] = '0;
    end else begin
      case (prv)
        LVL_GREEN: begin
          if (growth >= t) begin
            nxt = LVL_YELLOW;
            chan_stab[rq.ch] = '0;
          end
        end
        LVL_YELLOW: begin
          if (stp >= t) begin
            nxt = LVL_RED;
            chan_peak[rq.ch] = lvl;
            chan_stab[rq.ch] = '0;
          end else if (growth < t) begin
            nxt = LVL_GREEN;
            chan_base[rq.ch] = lvl;
            chan_stab[rq.ch] = '0;
          end else if (stp <= 0) begin
            if (chan_stab[rq.ch] != STABLE_MAX) chan_stab[rq.ch] = chan_stab[rq.ch] + 8'd1;
            if (chan_stab[rq.ch] >= cfg_stable) begin
              nxt = LVL_GREEN;
              chan_base[rq.ch] = lvl;
              chan_stab[rq.ch] = '0;
            end
          end else begin
            chan_stab[rq.ch] = '0;
          end
        end
        default: begin
          if (lvl > chan_peak[rq.ch]) chan_peak[rq.ch] = lvl;
          if (growth < t) begin
            nxt = LVL_GREEN;
            chan_base[rq.ch] = lvl;
            chan_stab[rq.ch] = '0;
          end else if (stp <= 0 && drop_reached(chan_peak[rq.ch], lvl)) begin
            nxt = LVL_YELLOW;
            chan_stab[rq.ch] = '0;
          end
        end
      endcase
    end
    chan_last[rq.ch] = lvl;
    chan_lvl[rq.ch]  = nxt;
    res.bucket = nxt;
    res.prev   = prv;
    res.on     = (nxt != prv) && (prv == LVL_GREEN);
    res.off    = (nxt != prv) && (nxt == LVL_GREEN);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Sender. A new request is put on the inputs at the falling edge only when
  // the previous one was taken or none was offered, so a stalled request
  // stays put, and valid never looks at the stall.
  always @(negedge clk_i) begin : sender
    request_t rq;
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (request_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        rq = request_q.pop_front();
        in_valid_i     <= 1'b1;
        kind_i         <= rq.kind;
        channel_i      <= rq.ch;
        level_kb_i     <= rq.level;
        threshold_kb_i <= rq.thr;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver. A long hold is counted down here once the stimulus asks for
  // one; otherwise the result side stalls at random.
  always @(negedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen   <= hold_seq;
      hold_left   <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < idle_pct);
    end
  end

  // Monitor. At each rising edge a delivered result is checked against the
  // oldest prediction, and an accepted request gets its prediction queued.
  always @(posedge clk_i) begin : monitor
    bucket_res_t want;
    request_t    rq;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (bucket_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result for channel %0d arrived with nothing pending", out_channel_o);
        end else begin
          want = bucket_exp_q.pop_front();
          check_field("out_channel", 32'(want.ch), 32'(out_channel_o));
          check_field("bucket", 32'(want.bucket), 32'(bucket_o));
          check_field("previous_bucket", 32'(want.prev), 32'(previous_bucket_o));
          check_field("trace_on", 32'(want.on), 32'(trace_on_o));
          check_field("trace_off", 32'(want.off), 32'(trace_off_o));
        end
      end
      req_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        rq = '{kind: kind_i, ch: channel_i, level: level_kb_i, thr: threshold_kb_i};
        bucket_exp_q.push_back(bucket_step(rq));
      end
    end
  end

  // Register write over the APB port: setup cycle, then the access cycle
  // that completes at the edge where pready is high.
  task automatic apb_write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_STABLE_NEEDED) cfg_stable = value[7:0];
    else cfg_drop = value[6:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_request(input logic kind, input logic [5:0] ch,
                              input logic [31:0] lvl, input logic [31:0] thr);
    request_q.push_back('{kind: kind, ch: ch, level: lvl, thr: thr});
    gen_started[ch] = 1'b1;
    gen_last[ch]    = lvl;
  endtask

  // Thresholds lean toward small values so that channels move between
  // levels often, with disabled, all-ones and fully random ones mixed in.
  function automatic logic [31:0] pick_threshold();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 10) return 32'd0;
    if (r < 15) return 32'hFFFF_FFFF;
    if (r < 25) return $urandom();
    if (r < 45) return $urandom_range(20, 1);
    return $urandom_range(1000, 1);
  endfunction

  // Random requests. Most are samples that move a started channel by a
  // step sized against its threshold, so that channels climb into yellow
  // and red and come back; a few are restarts, odd thresholds or wild levels.
  task automatic queue_random(input int count, input int chan_hi);
    int          i;
    logic [5:0]  ch;
    logic [31:0] thr;
    longint      t;
    longint      d;
    longint      lv;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99, 0) < 5) ch = 6'($urandom_range(NUM_CH - 1, 0));
      else ch = 6'($urandom_range(chan_hi, 0));
      if (!gen_started[ch] || $urandom_range(99, 0) < 4) begin
        gen_thr[ch] = pick_threshold();
        if ($urandom_range(3, 0) == 0) lv = longint'($urandom());
        else lv = longint'($urandom_range(100000, 0));
        push_request(KIND_START, ch, 32'(lv), $urandom());
        continue;
      end
      if ($urandom_range(99, 0) < 10) gen_thr[ch] = pick_threshold();
      thr = ($urandom_range(99, 0) < 4) ? $urandom() : gen_thr[ch];
      t = longint'(thr);
      case ($urandom_range(9, 0))
        0: d = 0;
        1: d = t;
        2: d = t - 1;
        3: d = -t;
        4: d = longint'($urandom_range(thr, 0)) * (($urandom_range(1, 0) != 0) ? 1 : -1);
        5: d = t + longint'($urandom_range(thr, 0));
        6: d = -longint'($urandom_range(thr / 4, 0));
        7: d = -1;
        8: d = 1;
        default: d = longint'($urandom()) - longint'(gen_last[ch]);
      endcase
      lv = longint'(gen_last[ch]) + d;
      if (lv < 0) lv = 0;
      if (lv > 64'hFFFF_FFFF) lv = 64'hFFFF_FFFF;
      push_request(KIND_SAMPLE, ch, 32'(lv), thr);
    end
  endtask

  // The sender runs dry and the test waits for every owed result, then lets
  // the clock run on so that the block is surely idle.
  task automatic wait_quiet();
    while (request_q.size() != 0 || in_valid_i || bucket_exp_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int          ph;
    logic [31:0] st;
    logic [31:0] dp;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, under the reset register values. Channel 0 walks the
    // whole cycle: green to yellow on growth, back to green after three
    // stable samples, yellow to red on a big step, red to yellow on a
    // twenty percent drop from the peak, and yellow to green on recovery.
    push_request(KIND_START,  6'd0, 32'd1000, 32'd7);
    push_request(KIND_SAMPLE, 6'd0, 32'd1000, 32'd100);
    push_request(KIND_SAMPLE, 6'd0, 32'd1100, 32'd100);
    push_request(KIND_SAMPLE, 6'd0, 32'd1100, 32'd100);
    push_request(KIND_SAMPLE, 6'd0, 32'd1100, 32'd100);
    push_request(KIND_SAMPLE, 6'd0, 32'd1100, 32'd100);
    push_request(KIND_SAMPLE, 6'd0, 32'd1250, 32'd100);
    push_request(KIND_SAMPLE, 6'd0, 32'd1400, 32'd100);
    push_request(KIND_SAMPLE, 6'd0, 32'd1500, 32'd100);
    push_request(KIND_SAMPLE, 6'd0, 32'd1200, 32'd100);
    push_request(KIND_SAMPLE, 6'd0, 32'd1150, 32'd100);
    // Channel 63 uses the level extremes, recovers from red straight to
    // green, and is restarted while red so the old level is reported.
    push_request(KIND_START,  6'd63, 32'd0,          32'd0);
    push_request(KIND_SAMPLE, 6'd63, 32'd5,          32'd5);
    push_request(KIND_SAMPLE, 6'd63, 32'hFFFF_FFFF, 32'd5);
    push_request(KIND_SAMPLE, 6'd63, 32'd0,          32'hFFFF_FFFF);
    push_request(KIND_SAMPLE, 6'd63, 32'd5,          32'd5);
    push_request(KIND_SAMPLE, 6'd63, 32'hFFFF_FFFF, 32'd5);
    push_request(KIND_START,  6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Channel 42: a zero threshold forces green from yellow and from red.
    push_request(KIND_START,  6'd42, 32'd100, 32'd1);
    push_request(KIND_SAMPLE, 6'd42, 32'd200, 32'd1);
    push_request(KIND_SAMPLE, 6'd42, 32'd200, 32'd0);
    push_request(KIND_SAMPLE, 6'd42, 32'd300, 32'd1);
    push_request(KIND_SAMPLE, 6'd42, 32'd400, 32'd1);
    push_request(KIND_SAMPLE, 6'd42, 32'd400, 32'd0);
    wait_quiet();

    // Random phases, each under its own register setting. The first few
    // take the extremes, including a stable count of zero and drop
    // percentages of zero and one hundred.
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin st = 32'd1;   dp = 32'd0;   end
        1: begin st = 32'd255; dp = 32'd100; end
        2: begin st = 32'd0;   dp = 32'd50;  end
        3: begin st = 32'd2;   dp = 32'd100; end
        default: begin
          st = $urandom_range(255, 1);
          dp = $urandom_range(100, 0);
        end
      endcase
      apb_write_reg(REG_STABLE_NEEDED, st);
      apb_write_reg(REG_FALL_PCT, dp);
      // One phase runs without any idling on either side.
      idle_pct = (ph == 2) ? 0 : 10;
      // One phase opens with a long receiver hold while the sender keeps
      // offering, so the block backs up and stalls its input.
      if (ph == 1) hold_seq++;
      queue_random(150, (ph == 3) ? NUM_CH - 1 : 7);
      wait_quiet();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && bucket_exp_q.size() == 0) begin
      $display("growth_level_bucket_tracker test passed");
    end else begin
      $display("growth_level_bucket_tracker test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("growth_level_bucket_tracker test failed");
    $finish;
  end

endmodule
